/* hdl/l3bs_pkg.sv */
// Shared types and constants for the L3 bus byte sender.
package l3bs_pkg;

  localparam int unsigned TICK_W      = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_INDEX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MODE_SETUP_HOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_HALF      = 2'd1;

  localparam logic [TICK_W-1:0] MODE_SETUP_HOLD_RST = 16'd190;
  localparam logic [TICK_W-1:0] CLOCK_HALF_RST      = 16'd250;

  // Transfer kinds carried in func
  localparam logic FUNC_ADDRESS = 1'b0;
  localparam logic FUNC_DATA    = 1'b1;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic              mode_level;
    logic              data_level;
    logic              clock_level;
    logic [TICK_W-1:0] hold_ticks;
    logic              last;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic              is_data;
    logic [BYTE_W-1:0] byte_value;
  } cmd_t;

  typedef struct packed {
    logic [TICK_W-1:0] mode_setup_hold;
    logic [TICK_W-1:0] clock_half;
  } timing_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

endpackage

/* hdl/l3_bus_byte_sender.sv */
// L3 bus byte sender top level: timing registers, front end, queue, back end.
// Path: accepted items pass the front-end register and queue to the output register.
// Throughput: one segment per cycle from the back-end sequencer unless the output
//   stalls; an item is 4+2*BITS_PER_BYTE segments (address) or 6+2*BITS_PER_BYTE (data).
// Reset: lines idle at mode 1, data 0, clock 1; timing registers load 190 and 250.
module l3_bus_byte_sender #(
  parameter int unsigned BITS_PER_BYTE = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  l3bs_pkg::in_item_t                  in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output l3bs_pkg::out_item_t                 out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [l3bs_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [l3bs_pkg::TICK_W-1:0]         cfg_data_i
);

  l3bs_pkg::timing_t   timing_q;
  l3bs_pkg::cmd_slot_t push;
  l3bs_pkg::cmd_slot_t head;
  logic                push_ready, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.mode_setup_hold <= l3bs_pkg::MODE_SETUP_HOLD_RST;
      timing_q.clock_half      <= l3bs_pkg::CLOCK_HALF_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        l3bs_pkg::REG_MODE_SETUP_HOLD: timing_q.mode_setup_hold <= cfg_data_i;
        l3bs_pkg::REG_CLOCK_HALF:      timing_q.clock_half      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  l3bs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_i         (in_i),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  l3bs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  l3bs_back #(
    .BITS_PER_BYTE (BITS_PER_BYTE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timing_i    (timing_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

/* hdl/l3bs_front.sv */
// Front end: accepts input transactions and classifies them into commands.
module l3bs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  l3bs_pkg::in_item_t  in_i,
  output l3bs_pkg::cmd_slot_t push_o,
  input  logic                push_ready_i
);

  logic          valid_q, valid_d;
  l3bs_pkg::cmd_t cmd_q;
  logic          accept;

  assign in_stall_o = valid_q && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.is_data    <= (in_i.func == l3bs_pkg::FUNC_DATA);
      cmd_q.byte_value <= in_i.byte_value;
    end
  end

  assign push_o.valid = valid_q;
  assign push_o.cmd   = cmd_q;

endmodule

/* hdl/l3bs_fifo.sv */
// Two-entry command queue between front and back.
module l3bs_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  l3bs_pkg::cmd_slot_t push_i,
  output logic                push_ready_o,
  output l3bs_pkg::cmd_slot_t head_o,
  input  logic                pop_i
);

  l3bs_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign push         = push_i.valid && push_ready_o;
  assign pop          = pop_i && (count_q != 2'd0);

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

endmodule

/* hdl/l3bs_back.sv */
// Back end: segment sequencer and output register.
module l3bs_back #(
  parameter int unsigned BITS_PER_BYTE = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  l3bs_pkg::timing_t   timing_i,
  input  l3bs_pkg::cmd_slot_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output l3bs_pkg::out_item_t out_o
);

  localparam int unsigned BIT_W = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BITS_PER_BYTE - 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PRE  = 2'd1;
  localparam logic [1:0] PH_BITS = 2'd2;
  localparam logic [1:0] PH_POST = 2'd3;

  logic [1:0]                  phase_q;
  logic [1:0]                  step_q;
  logic [BIT_W-1:0]            bit_q;
  logic                        half_q;
  logic                        is_data_q;
  logic [l3bs_pkg::BYTE_W-1:0] shreg_q;
  logic                        data_q;   // persistent data line level

  logic                        out_valid_q;
  l3bs_pkg::out_item_t         out_q;

  logic                        advance, emit, idle, cur_is_data, zero_hold;
  logic [1:0]                  last_step;
  l3bs_pkg::out_item_t         seg;

  assign advance     = !out_valid_q || !out_stall_i;
  assign idle        = (phase_q == PH_IDLE);
  assign emit        = idle ? head_i.valid : 1'b1;
  assign pop_o       = advance && idle && head_i.valid;
  assign cur_is_data = idle ? head_i.cmd.is_data : is_data_q;
  assign last_step   = cur_is_data ? 2'd2 : 2'd1;

  // Zero-hold segments: momentary mode-line pulses around a data transfer
  assign zero_hold = cur_is_data &&
                     (((phase_q == PH_IDLE) && (step_q == 2'd0)) ||
                      ((phase_q == PH_POST) && (step_q == 2'd2)));

  always_comb begin
    seg = '0;
    if (phase_q == PH_BITS) begin
      seg.mode_level  = is_data_q;
      seg.clock_level = half_q;
      seg.data_level  = half_q ? data_q : shreg_q[0];
      seg.hold_ticks  = timing_i.clock_half;
      seg.last        = 1'b0;
    end else begin
      if (cur_is_data) begin
        seg.mode_level = (step_q != 2'd1);
      end else if (phase_q == PH_POST) begin
        seg.mode_level = (step_q == 2'd1);
      end else begin
        seg.mode_level = (step_q == 2'd0);
      end
      seg.clock_level = 1'b1;
      seg.data_level  = data_q;
      seg.hold_ticks  = zero_hold ? '0 : timing_i.mode_setup_hold;
      seg.last        = (phase_q == PH_POST) && (step_q == last_step);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      step_q      <= 2'd0;
      bit_q       <= '0;
      half_q      <= 1'b0;
      data_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
      case (phase_q)
        PH_IDLE: begin
          if (head_i.valid) begin
            phase_q <= PH_PRE;
            step_q  <= 2'd1;
          end
        end
        PH_PRE: begin
          if (step_q == last_step) begin
            phase_q <= PH_BITS;
            step_q  <= 2'd0;
            bit_q   <= '0;
            half_q  <= 1'b0;
          end else begin
            step_q <= step_q + 2'd1;
          end
        end
        PH_BITS: begin
          if (!half_q) begin
            data_q <= shreg_q[0];
            half_q <= 1'b1;
          end else begin
            half_q <= 1'b0;
            if (bit_q == LAST_BIT) begin
              phase_q <= PH_POST;
            end else begin
              bit_q <= bit_q + BIT_W'(1);
            end
          end
        end
        PH_POST: begin
          if (step_q == last_step) begin
            phase_q <= PH_IDLE;
            step_q  <= 2'd0;
          end else begin
            step_q <= step_q + 2'd1;
          end
        end
        default: begin
          phase_q <= PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= seg;
      if (idle && head_i.valid) begin
        is_data_q <= head_i.cmd.is_data;
        shreg_q   <= head_i.cmd.byte_value;
      end else if ((phase_q == PH_BITS) && half_q) begin
        // bits above the byte shift in as zero
        shreg_q <= {1'b0, shreg_q[l3bs_pkg::BYTE_W-1:1]};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* hdl/l3bs_checker.sv */
// Port-level assertions for the L3 bus byte sender, bound to the top level.
module l3bs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input l3bs_pkg::out_item_t out_o
);

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_o))
    else $error("output payload changed while stalled");

  // a run always ends with the bus back at idle levels
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.last |-> out_o.mode_level && out_o.clock_level)
    else $error("last segment does not leave bus idle");

  // a clock-low half is always followed at once by its clock-high half
  a_clock_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_o.clock_level |=>
      out_valid_o && out_o.clock_level && !out_o.last)
    else $error("clock-low half not followed by clock-high half");

endmodule

bind l3_bus_byte_sender l3bs_checker u_checker (.*);
